[design/hbs_pkg.sv]
package hbs_pkg;

    localparam int COORD_W   = 8;
    localparam int CHAN_W    = 8;
    localparam int HEIGHT_W  = 8;
    localparam int REG_W     = 9;
    localparam int CMD_W     = 2;
    localparam int SUM_OUT_W = 13;
    localparam int MEAN_W    = 16;
    localparam int FRAC_W    = 8;

    localparam int DEF_MAX_COLUMNS = 256;
    localparam int DEF_MAX_ROWS    = 256;
    localparam int DEF_RADIUS      = 2;

    localparam logic [REG_W-1:0] MAP_SIZE_RESET = 9'd256;

    // floor(s/3) for s <= 765 as (s * 683) >> 11.
    localparam int RGB_SUM_W  = 10;
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int DIV3_PW    = 20;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_RAW    = 2'd1,
        CMD_SMOOTH = 2'd2
    } cmd_t;

    typedef enum logic {
        CFG_MAP_WIDTH  = 1'b0,
        CFG_MAP_LENGTH = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV,
        ST_WAIT
    } seq_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
    } item_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0]  cell_height;
        logic [SUM_OUT_W-1:0] window_sum;
        logic [MEAN_W-1:0]    smoothed;
        logic [HEIGHT_W-1:0]  peak_height;
    } result_t;

    function automatic logic [HEIGHT_W-1:0] rgb_to_height(
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b
    );
        logic [RGB_SUM_W-1:0] s;
        logic [DIV3_PW-1:0]   p;
        s = RGB_SUM_W'(r) + RGB_SUM_W'(g) + RGB_SUM_W'(b);
        p = DIV3_PW'(s) * DIV3_PW'(DIV3_MUL);
        return p[DIV3_SHIFT +: HEIGHT_W];
    endfunction

endpackage

[design/heightmap_box_smoother.sv]
// Height map with box smoothing. A command is taken when start is high and
// busy is low; its result appears for exactly one cycle with done high, and
// the receiver cannot stall it. All heights live in one single-port memory
// of MAX_COLUMNS*MAX_ROWS bytes, and that one port sets the pace: a load
// makes at most one write, a raw query at most one read, and a smoothed
// query one scan step per window position, reading each position inside
// the map, plus a read drain and a two-stage divide by the window size.
// A new command may be started in the cycle its predecessor's result
// is shown. map_width and map_length may be written only while the block
// is idle. Reading a cell inside the map that was never loaded gives an
// undefined height.
module heightmap_box_smoother #(
    parameter int MAX_COLUMNS = hbs_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = hbs_pkg::DEF_MAX_ROWS,
    parameter int RADIUS      = hbs_pkg::DEF_RADIUS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic [hbs_pkg::CMD_W-1:0]     cmd,
    input  logic [hbs_pkg::COORD_W-1:0]   x,
    input  logic [hbs_pkg::COORD_W-1:0]   y,
    input  logic [hbs_pkg::CHAN_W-1:0]    red,
    input  logic [hbs_pkg::CHAN_W-1:0]    green,
    input  logic [hbs_pkg::CHAN_W-1:0]    blue,
    output logic [hbs_pkg::HEIGHT_W-1:0]  cell_height,
    output logic [hbs_pkg::SUM_OUT_W-1:0] window_sum,
    output logic [hbs_pkg::MEAN_W-1:0]    smoothed,
    output logic [hbs_pkg::HEIGHT_W-1:0]  peak_height,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [hbs_pkg::REG_W-1:0]     cfg_data
);

    import hbs_pkg::*;

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CELLS = (2 * RADIUS + 1) * (2 * RADIUS + 1);
    localparam int SUM_W = $clog2(CELLS * 255 + 1);
    localparam int N_W   = SUM_W + FRAC_W;

    logic [REG_W-1:0]    map_width_reg, map_length_reg;
    item_t               item;
    result_t             result;
    logic                mem_en, mem_we;
    logic [AW-1:0]       mem_addr;
    logic [HEIGHT_W-1:0] mem_wdata, mem_rdata;
    logic                div_start, div_valid;
    logic [N_W-1:0]      div_dividend, div_quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= MAP_SIZE_RESET;
            map_length_reg <= MAP_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                CFG_MAP_LENGTH: map_length_reg <= cfg_data;
                default:        map_width_reg  <= map_width_reg;
            endcase
        end
    end

    always_comb
    begin
        item.cmd   = cmd;
        item.x     = x;
        item.y     = y;
        item.red   = red;
        item.green = green;
        item.blue  = blue;
    end

    hbs_seq #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .RADIUS      (RADIUS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .map_width    (map_width_reg),
        .map_length   (map_length_reg),
        .busy         (busy),
        .done         (done),
        .result       (result),
        .mem_en       (mem_en),
        .mem_we       (mem_we),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .mem_rdata    (mem_rdata),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_valid    (div_valid),
        .div_quotient (div_quotient)
    );

    hbs_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (HEIGHT_W)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    hbs_div #(
        .DIVISOR (CELLS),
        .N_W     (N_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .valid    (div_valid),
        .quotient (div_quotient)
    );

    assign cell_height = result.cell_height;
    assign window_sum  = result.window_sum;
    assign smoothed    = result.smoothed;
    assign peak_height = result.peak_height;

endmodule

[design/hbs_mem.sv]
module hbs_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 8
) (
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] store [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                store[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= store[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/hbs_div.sv]
module hbs_div #(
    parameter int DIVISOR = 25,
    parameter int N_W     = 21
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    output logic           valid,
    output logic [N_W-1:0] quotient
);

    import hbs_pkg::*;

    localparam longint RECIP = (longint'(1) << N_W) / DIVISOR;
    localparam int     M_W   = $clog2(RECIP + 1);
    localparam int     PW    = N_W + M_W;

    logic [PW-1:0]  prod_reg;
    logic [N_W-1:0] num_reg;
    logic           stage1_reg;
    logic           valid_reg;
    logic [N_W-1:0] quotient_reg;

    logic [M_W-1:0] q_est;
    logic [N_W-1:0] rem;
    logic [N_W-1:0] q_fix;

    // The truncated reciprocal undershoots by at most one, so a single
    // remainder check finishes the quotient.
    assign q_est = prod_reg[N_W +: M_W];

    always_comb
    begin
        rem   = num_reg - N_W'(q_est) * N_W'(DIVISOR);
        q_fix = (rem >= N_W'(DIVISOR)) ? N_W'(q_est) + N_W'(1) : N_W'(q_est);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            stage1_reg <= start;
            valid_reg  <= stage1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PW'(dividend) * PW'(RECIP);
            num_reg  <= dividend;
        end
        if (stage1_reg)
        begin
            quotient_reg <= q_fix;
        end
    end

    assign valid    = valid_reg;
    assign quotient = quotient_reg;

endmodule

[design/hbs_seq.sv]
module hbs_seq #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256,
    parameter int RADIUS      = 2,
    localparam int AW         = $clog2(MAX_COLUMNS * MAX_ROWS),
    localparam int CELLS      = (2 * RADIUS + 1) * (2 * RADIUS + 1),
    localparam int SUM_W      = $clog2(CELLS * 255 + 1),
    localparam int N_W        = SUM_W + hbs_pkg::FRAC_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  hbs_pkg::item_t               item,
    input  logic [hbs_pkg::REG_W-1:0]    map_width,
    input  logic [hbs_pkg::REG_W-1:0]    map_length,
    output logic                         busy,
    output logic                         done,
    output hbs_pkg::result_t             result,
    output logic                         mem_en,
    output logic                         mem_we,
    output logic [AW-1:0]                mem_addr,
    output logic [hbs_pkg::HEIGHT_W-1:0] mem_wdata,
    input  logic [hbs_pkg::HEIGHT_W-1:0] mem_rdata,
    output logic                         div_start,
    output logic [N_W-1:0]               div_dividend,
    input  logic                         div_valid,
    input  logic [N_W-1:0]               div_quotient
);

    import hbs_pkg::*;

    localparam int SIDE  = 2 * RADIUS + 1;
    localparam int OFS_W = $clog2(SIDE);
    localparam int CXP_W = $clog2((2 ** COORD_W) + 2 * RADIUS);
    localparam int LIM_W = ((CXP_W > REG_W) ? CXP_W : REG_W) + 1;

    seq_state_t state_reg, state_next;

    logic [COORD_W-1:0]  x_reg, y_reg;
    logic [CHAN_W-1:0]   red_reg, green_reg, blue_reg;
    logic                smooth_reg;
    logic [OFS_W-1:0]    dx_reg, dx_next, dy_reg, dy_next;
    logic                rd_active_reg, rd_hit_reg, rd_center_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [HEIGHT_W-1:0] cell_reg;
    logic [HEIGHT_W-1:0] peak_reg, peak_next;
    result_t             result_reg, result_next;
    logic                done_reg, done_next;

    logic [REG_W-1:0]    cols_used, rows_used;
    logic [CXP_W-1:0]    cxp, cyp, cell_x, cell_y;
    logic [LIM_W-1:0]    x_lim, y_lim;
    logic                in_range, is_center, last_pos, accept;
    logic [HEIGHT_W-1:0] rd_word, cell_cur, height;

    assign accept = start && (state_reg == ST_IDLE);

    assign cols_used = (32'(map_width) > MAX_COLUMNS) ? REG_W'(MAX_COLUMNS) : map_width;
    assign rows_used = (32'(map_length) > MAX_ROWS) ? REG_W'(MAX_ROWS) : map_length;

    // Window positions are kept biased by RADIUS so that they stay unsigned.
    assign cxp    = CXP_W'(x_reg) + CXP_W'(dx_reg);
    assign cyp    = CXP_W'(y_reg) + CXP_W'(dy_reg);
    assign x_lim  = LIM_W'(cols_used) + LIM_W'(RADIUS);
    assign y_lim  = LIM_W'(rows_used) + LIM_W'(RADIUS);
    assign cell_x = cxp - CXP_W'(RADIUS);
    assign cell_y = cyp - CXP_W'(RADIUS);

    assign in_range = (LIM_W'(cxp) >= LIM_W'(RADIUS)) && (LIM_W'(cxp) < x_lim)
                   && (LIM_W'(cyp) >= LIM_W'(RADIUS)) && (LIM_W'(cyp) < y_lim);

    assign is_center = (dx_reg == OFS_W'(RADIUS)) && (dy_reg == OFS_W'(RADIUS));
    assign last_pos  = !smooth_reg
                    || ((dx_reg == OFS_W'(SIDE - 1)) && (dy_reg == OFS_W'(SIDE - 1)));

    assign rd_word  = rd_hit_reg ? mem_rdata : '0;
    assign cell_cur = rd_center_reg ? rd_word : cell_reg;
    assign height   = rgb_to_height(red_reg, green_reg, blue_reg);

    assign mem_addr     = AW'(cell_y) * AW'(MAX_COLUMNS) + AW'(cell_x);
    assign mem_wdata    = height;
    assign div_dividend = {sum_reg, FRAC_W'(0)};

    always_comb
    begin
        state_next  = state_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        peak_next   = peak_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        mem_en      = 1'b0;
        mem_we      = 1'b0;
        div_start   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (item.cmd == CMD_LOAD)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                    // Raw queries and loads use only the center position.
                    if (item.cmd == CMD_SMOOTH)
                    begin
                        dx_next = '0;
                        dy_next = '0;
                    end
                    else
                    begin
                        dx_next = OFS_W'(RADIUS);
                        dy_next = OFS_W'(RADIUS);
                    end
                end
            end
            ST_LOAD:
            begin
                mem_en = in_range;
                mem_we = 1'b1;
                if (in_range && (height > peak_reg))
                begin
                    peak_next = height;
                end
                result_next.cell_height = height;
                result_next.window_sum  = '0;
                result_next.smoothed    = '0;
                result_next.peak_height = peak_next;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                mem_en = in_range;
                if (dy_reg == OFS_W'(SIDE - 1))
                begin
                    dy_next = '0;
                    dx_next = dx_reg + OFS_W'(1);
                end
                else
                begin
                    dy_next = dy_reg + OFS_W'(1);
                end
                if (last_pos)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (smooth_reg)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    result_next.cell_height = cell_cur;
                    result_next.window_sum  = '0;
                    result_next.smoothed    = '0;
                    result_next.peak_height = peak_reg;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_valid)
                begin
                    result_next.cell_height = cell_reg;
                    result_next.window_sum  = SUM_OUT_W'(sum_reg);
                    result_next.smoothed    = MEAN_W'(div_quotient);
                    result_next.peak_height = peak_reg;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dx_reg        <= '0;
            dy_reg        <= '0;
            peak_reg      <= '0;
            done_reg      <= 1'b0;
            rd_active_reg <= 1'b0;
            rd_hit_reg    <= 1'b0;
            rd_center_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            peak_reg      <= peak_next;
            done_reg      <= done_next;
            rd_active_reg <= (state_reg == ST_SCAN);
            rd_hit_reg    <= (state_reg == ST_SCAN) && in_range;
            rd_center_reg <= (state_reg == ST_SCAN) && is_center;
        end
    end

    // Read data is registered in the memory and comes back in the cycle after
    // the address, so each beat of the scan is accumulated on the following cycle.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            x_reg      <= item.x;
            y_reg      <= item.y;
            red_reg    <= item.red;
            green_reg  <= item.green;
            blue_reg   <= item.blue;
            smooth_reg <= (item.cmd == CMD_SMOOTH);
            sum_reg    <= '0;
            cell_reg   <= '0;
        end
        else if (rd_active_reg)
        begin
            sum_reg  <= sum_reg + SUM_W'(rd_word);
            cell_reg <= cell_cur;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
